// ===== hw/rtl/bouncing_ball_step_top_assert.svh =====
// Assertion macros for the bouncing ball step block.
// Included by the RTL files that check their own sequencing; needs no package.
`ifndef BOUNCING_BALL_STEP_TOP_ASSERT_SVH
`define BOUNCING_BALL_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BBS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("bouncing_ball_step: assertion failed");
// next-cycle implication
`define BBS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("bouncing_ball_step: assertion failed");
`else
`define BBS_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define BBS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== hw/rtl/bbs_pkg.sv =====
// Package for the bouncing ball step block: widths, reset values, codes,
// configuration struct and saturation helper. No dependencies.
`default_nettype none

package bbs_pkg;

	localparam int FRAC_BITS = 8;
	localparam int POS_W     = 24;
	localparam int OPA_W     = POS_W + 1;   // room for a negated velocity
	localparam int OPB_W     = 18;          // signed Q1.16 factor, raw value up to 65536
	localparam int ACC_W     = 44;
	localparam int WIDE_W    = 48;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int ALPHA_W   = 16;
	localparam int Q16_ROUND = 32768;

	localparam logic signed [WIDE_W-1:0] POS_MAX = WIDE_W'((64'sd1 <<< (POS_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] POS_MIN = -POS_MAX - WIDE_W'(1);

	localparam logic signed [POS_W-1:0] PX_RST = POS_W'(400 << FRAC_BITS);
	localparam logic signed [POS_W-1:0] PY_RST = POS_W'(300 << FRAC_BITS);
	localparam logic signed [POS_W-1:0] VX_RST = POS_W'(100 << FRAC_BITS);
	localparam logic signed [POS_W-1:0] VY_RST = '0;

	typedef struct packed {
		logic [11:0]        field_width;
		logic [11:0]        field_height;
		logic [9:0]         ball_radius;
		logic signed [16:0] gravity_step;
		logic [15:0]        time_step;
		logic [15:0]        air_damping;
		logic [15:0]        restitution;
		logic [15:0]        ground_friction;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		field_width:     12'd800,
		field_height:    12'd600,
		ball_radius:     10'd25,
		gravity_step:    -17'sd1280,
		time_step:       16'd655,
		air_damping:     16'd65470,
		restitution:     16'd55706,
		ground_friction: 16'd64225
	};

	typedef enum logic [2:0] {
		REG_FIELD_WIDTH,
		REG_FIELD_HEIGHT,
		REG_BALL_RADIUS,
		REG_GRAVITY_STEP,
		REG_TIME_STEP,
		REG_AIR_DAMPING,
		REG_RESTITUTION,
		REG_GROUND_FRICTION
	} reg_idx_t;

	typedef enum logic {
		FUNC_STEP,
		FUNC_QUERY
	} func_t;

	typedef enum logic [3:0] {
		OP_GRAV,
		OP_DAMP_X,
		OP_DAMP_Y,
		OP_MOVE_X,
		OP_MOVE_Y,
		OP_WALL_X,
		OP_WALL_Y,
		OP_FRIC,
		OP_BL_PX,
		OP_BL_PY,
		OP_BL_VX,
		OP_BL_VY
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;    // load the accumulator
		logic acc;   // add to it instead of replacing
	} mac_ctl_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_MAX) begin
			r = POS_W'(POS_MAX);
		end else if (v < POS_MIN) begin
			r = POS_W'(POS_MIN);
		end else begin
			r = POS_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bbs_chan_if.sv =====
// Valid/ready channel interfaces for the bouncing ball step block.
// Depends on bbs_pkg for payload widths.
`default_nettype none

interface bbs_req_if;
	import bbs_pkg::*;
	logic               valid;
	logic               ready;
	logic               func;
	logic [ALPHA_W-1:0] alpha;

	modport source (output valid, func, alpha, input ready);
	modport sink (input valid, func, alpha, output ready);
endinterface

interface bbs_rsp_if;
	import bbs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] vel_x;
	logic signed [POS_W-1:0] vel_y;
	logic                    on_ground;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, on_ground, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, on_ground, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bbs_regs.sv =====
// APB configuration registers for the bouncing ball step block.
// Depends on bbs_pkg (cfg_t, register codes).
`default_nettype none

module bbs_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bbs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bbs_pkg::DATA_W-1:0] pwdata,
	output logic      [bbs_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output bbs_pkg::cfg_t                   cfg
);
	import bbs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_FIELD_WIDTH:     cfg_q.field_width     <= pwdata[11:0];
				REG_FIELD_HEIGHT:    cfg_q.field_height    <= pwdata[11:0];
				REG_BALL_RADIUS:     cfg_q.ball_radius     <= pwdata[9:0];
				REG_GRAVITY_STEP:    cfg_q.gravity_step    <= signed'(pwdata[16:0]);
				REG_TIME_STEP:       cfg_q.time_step       <= pwdata[15:0];
				REG_AIR_DAMPING:     cfg_q.air_damping     <= pwdata[15:0];
				REG_RESTITUTION:     cfg_q.restitution     <= pwdata[15:0];
				REG_GROUND_FRICTION: cfg_q.ground_friction <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FIELD_WIDTH:     prdata = DATA_W'(cfg_q.field_width);
			REG_FIELD_HEIGHT:    prdata = DATA_W'(cfg_q.field_height);
			REG_BALL_RADIUS:     prdata = DATA_W'(cfg_q.ball_radius);
			REG_GRAVITY_STEP:    prdata = DATA_W'(cfg_q.gravity_step);
			REG_TIME_STEP:       prdata = DATA_W'(cfg_q.time_step);
			REG_AIR_DAMPING:     prdata = DATA_W'(cfg_q.air_damping);
			REG_RESTITUTION:     prdata = DATA_W'(cfg_q.restitution);
			REG_GROUND_FRICTION: prdata = DATA_W'(cfg_q.ground_friction);
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bbs_mac.sv =====
// Shared multiply-accumulate unit with Q16 round-half-up and 24-bit saturation.
// Depends on bbs_pkg (widths, mac_ctl_t, sat_pos).
`default_nettype none

module bbs_mac (
	input  wire logic                             clk,
	input  wire bbs_pkg::mac_ctl_t                ctl,
	input  wire logic signed [bbs_pkg::OPA_W-1:0] op_a,
	input  wire logic signed [bbs_pkg::OPB_W-1:0] op_b,
	output logic signed      [bbs_pkg::POS_W-1:0] res
);
	import bbs_pkg::*;

	logic signed [OPA_W+OPB_W-1:0] prod;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       rnd;

	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= ctl.acc ? acc_q + ACC_W'(prod) : ACC_W'(prod);
		end
	end

	// floor shift after adding half an LSB
	assign rnd = (acc_q + ACC_W'(Q16_ROUND)) >>> 16;
	assign res = sat_pos(WIDE_W'(rnd));

endmodule

`default_nettype wire

// ===== hw/rtl/bouncing_ball_step_top.sv =====
// Top level of the bouncing ball step block: sequencer, ball state, output register.
// Depends on bbs_pkg, bbs_chan_if, bbs_regs, bbs_mac and the assertion header.
//
//  channel | kind        | direction | payload
//  --------+-------------+-----------+------------------------------------------
//  req     | valid/ready | in        | func, alpha
//  rsp     | valid/ready | out       | pos_x, pos_y, vel_x, vel_y, on_ground
//  apb     | APB r/w     | in        | 8 registers at byte address 4*index
//
// One 25x18 multiplier with accumulator is shared; each product is multiplied into the
// accumulator, then rounded, saturated and written back; a blend adds its second product first.
// Step: gravity add, 7 products, then the output load.
// Query: 4 blends of two products each, then the output load. req.ready is high only while
// idle; a result waits in the output register, and a finished item holds the sequencer until
// that register is free.
// Reset (arst_n low) restores registers and ball state at once; no clearing pass.
`include "bouncing_ball_step_top_assert.svh"
`default_nettype none

module bouncing_ball_step_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bbs_req_if.sink                         req,
	bbs_rsp_if.source                       rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bbs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bbs_pkg::DATA_W-1:0] pwdata,
	output logic      [bbs_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import bbs_pkg::*;

	cfg_t   cfg;
	state_t state_q, state_d;
	op_t    op_q;
	logic [1:0] ph_q, last_ph;
	logic   func_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic signed [POS_W-1:0] px_q, py_q, vx_q, vy_q;
	logic signed [POS_W-1:0] ppx_q, ppy_q, pvx_q, pvy_q;
	logic signed [POS_W-1:0] bpx_q, bpy_q, bvx_q, bvy_q;

	logic signed [POS_W-1:0] opos_x_q, opos_y_q, ovel_x_q, ovel_y_q;
	logic out_v_q, ogrnd_q;

	mac_ctl_t mac_ctl;
	logic signed [OPA_W-1:0] op_a;
	logic signed [OPB_W-1:0] op_b;
	logic signed [POS_W-1:0] mac_res;

	logic accept, wb, last_op, is_blend, load_out, grounded;
	logic signed [WIDE_W-1:0] rad_w, lo_w, hi_w, wpos_w;
	logic hit_lo, hit_hi;

	bbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bbs_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (op_a),
		.op_b (op_b),
		.res  (mac_res)
	);

	// shared wall compare: x wall during OP_WALL_X, y otherwise
	assign rad_w  = signed'(WIDE_W'(cfg.ball_radius));
	assign lo_w   = rad_w <<< FRAC_BITS;
	assign hi_w   = ((op_q == OP_WALL_X) ? signed'(WIDE_W'(cfg.field_width))
		: signed'(WIDE_W'(cfg.field_height))) - rad_w <<< FRAC_BITS;
	assign wpos_w = WIDE_W'((op_q == OP_WALL_X) ? px_q : py_q);
	assign hit_lo = wpos_w <= lo_w;
	assign hit_hi = wpos_w >= hi_w;
	assign grounded = WIDE_W'(py_q) <= lo_w;

	assign is_blend = (op_q == OP_BL_PX) || (op_q == OP_BL_PY)
		|| (op_q == OP_BL_VX) || (op_q == OP_BL_VY);
	assign last_ph  = is_blend ? 2'd2 : ((op_q == OP_GRAV) ? 2'd0 : 2'd1);
	assign wb       = (state_q == ST_RUN) && (ph_q == last_ph);
	assign last_op  = (op_q == OP_FRIC) || (op_q == OP_BL_VY);
	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == ST_DONE) && (!out_v_q || rsp.ready);

	assign mac_ctl.en  = (state_q == ST_RUN) && (ph_q != last_ph);
	assign mac_ctl.acc = (ph_q == 2'd1);

	// operand select
	always_comb begin
		op_a = OPA_W'(vx_q);
		op_b = OPB_W'(cfg.air_damping);
		unique case (op_q)
			OP_GRAV, OP_DAMP_X: begin
				op_a = OPA_W'(vx_q);
				op_b = OPB_W'(cfg.air_damping);
			end
			OP_DAMP_Y: begin
				op_a = OPA_W'(vy_q);
				op_b = OPB_W'(cfg.air_damping);
			end
			OP_MOVE_X: begin
				op_a = OPA_W'(vx_q);
				op_b = OPB_W'(cfg.time_step);
			end
			OP_MOVE_Y: begin
				op_a = OPA_W'(vy_q);
				op_b = OPB_W'(cfg.time_step);
			end
			OP_WALL_X: begin
				op_a = -OPA_W'(vx_q);
				op_b = OPB_W'(cfg.restitution);
			end
			OP_WALL_Y: begin
				op_a = -OPA_W'(vy_q);
				op_b = OPB_W'(cfg.restitution);
			end
			OP_FRIC: begin
				op_a = OPA_W'(vx_q);
				op_b = OPB_W'(cfg.ground_friction);
			end
			OP_BL_PX: op_a = OPA_W'((ph_q == 2'd0) ? px_q : ppx_q);
			OP_BL_PY: op_a = OPA_W'((ph_q == 2'd0) ? py_q : ppy_q);
			OP_BL_VX: op_a = OPA_W'((ph_q == 2'd0) ? vx_q : pvx_q);
			OP_BL_VY: op_a = OPA_W'((ph_q == 2'd0) ? vy_q : pvy_q);
			default: begin
				op_a = OPA_W'(vx_q);
				op_b = OPB_W'(cfg.air_damping);
			end
		endcase
		if (is_blend) begin
			// previous weight is one minus alpha
			op_b = (ph_q == 2'd0) ? OPB_W'(alpha_q)
				: OPB_W'(17'h10000 - 17'(alpha_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (wb && last_op) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer position and latched request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_GRAV;
			ph_q    <= '0;
			func_q  <= 1'b0;
			alpha_q <= '0;
		end else if (accept) begin
			func_q  <= req.func;
			alpha_q <= req.alpha;
			op_q    <= (func_t'(req.func) == FUNC_QUERY) ? OP_BL_PX : OP_GRAV;
			ph_q    <= '0;
		end else if (state_q == ST_RUN) begin
			if (wb) begin
				ph_q <= '0;
				if (!last_op) begin
					op_q <= op_t'(op_q + 4'd1);
				end
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	// ball state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= PX_RST;
			py_q  <= PY_RST;
			vx_q  <= VX_RST;
			vy_q  <= VY_RST;
			ppx_q <= PX_RST;
			ppy_q <= PY_RST;
			pvx_q <= VX_RST;
			pvy_q <= VY_RST;
		end else if (wb) begin
			unique case (op_q)
				OP_GRAV: begin
					ppx_q <= px_q;
					ppy_q <= py_q;
					pvx_q <= vx_q;
					pvy_q <= vy_q;
					vy_q  <= sat_pos(WIDE_W'(vy_q) + WIDE_W'(cfg.gravity_step));
				end
				OP_DAMP_X: vx_q <= mac_res;
				OP_DAMP_Y: vy_q <= mac_res;
				OP_MOVE_X: px_q <= sat_pos(WIDE_W'(px_q) + WIDE_W'(mac_res));
				OP_MOVE_Y: py_q <= sat_pos(WIDE_W'(py_q) + WIDE_W'(mac_res));
				OP_WALL_X: begin
					if (hit_lo || hit_hi) begin
						vx_q <= mac_res;
						px_q <= sat_pos(hit_lo ? lo_w : hi_w);
					end
				end
				OP_WALL_Y: begin
					if (hit_lo || hit_hi) begin
						vy_q <= mac_res;
						py_q <= sat_pos(hit_lo ? lo_w : hi_w);
					end
				end
				OP_FRIC: begin
					if (grounded) begin
						vx_q <= mac_res;
					end
				end
				default: ;
			endcase
		end
	end

	// blend results, payload only
	always_ff @(posedge clk) begin
		if (wb) begin
			unique case (op_q)
				OP_BL_PX: bpx_q <= mac_res;
				OP_BL_PY: bpy_q <= mac_res;
				OP_BL_VX: bvx_q <= mac_res;
				OP_BL_VY: bvy_q <= mac_res;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			opos_x_q <= func_q ? bpx_q : px_q;
			opos_y_q <= func_q ? bpy_q : py_q;
			ovel_x_q <= func_q ? bvx_q : vx_q;
			ovel_y_q <= func_q ? bvy_q : vy_q;
			ogrnd_q  <= grounded;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.pos_x     = opos_x_q;
	assign rsp.pos_y     = opos_y_q;
	assign rsp.vel_x     = ovel_x_q;
	assign rsp.vel_y     = ovel_y_q;
	assign rsp.on_ground = ogrnd_q;

	`BBS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`BBS_ASSERT_IMPL(a_phase_range, clk, arst_n, state_q == ST_RUN, ph_q <= last_ph)
	`BBS_ASSERT_IMPL(a_out_from_done, clk, arst_n, $rose(rsp.valid), $past(state_q) == ST_DONE)
	`BBS_ASSERT_NEXT(a_prev_saved, clk, arst_n, wb && op_q == OP_GRAV, ppx_q == $past(px_q))

endmodule

`default_nettype wire
